// ===== rtl/core/ihc_pkg.sv =====
// ----------------------------------------------------------------------------
// ihc_pkg
// Shared types, protocol codes and helpers for the IP header classifier.
// ----------------------------------------------------------------------------
package ihc_pkg;

  // default sizing
  localparam int MAX_PACKET_BYTES_DEF = 2047;
  localparam int MAX_EXT_HEADERS_DEF  = 8;

  // IP versions
  localparam logic [3:0] IP_V4 = 4'd4;
  localparam logic [3:0] IP_V6 = 4'd6;

  // transport protocols
  localparam logic [7:0] PR_ICMP   = 8'd1;
  localparam logic [7:0] PR_TCP    = 8'd6;
  localparam logic [7:0] PR_UDP    = 8'd17;
  localparam logic [7:0] PR_ICMPV6 = 8'd58;

  // IPv6 extension header codes
  localparam logic [7:0] EXT_HOP_BY_HOP = 8'd0;
  localparam logic [7:0] EXT_ROUTING    = 8'd43;
  localparam logic [7:0] EXT_FRAGMENT   = 8'd44;
  localparam logic [7:0] EXT_ESP        = 8'd50;
  localparam logic [7:0] EXT_AUTH       = 8'd51;
  localparam logic [7:0] EXT_DEST_OPTS  = 8'd60;
  localparam logic [7:0] EXT_MOBILITY   = 8'd135;

  // fixed header geometry
  localparam int V4_MIN_HDR   = 20;
  localparam int V4_MIN_IHL   = 5;
  localparam int V6_HDR_BYTES = 40;
  localparam int TCP_HDR_MIN  = 20;
  localparam int L4_HDR_MIN   = 8;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_HDR_SHORT    = 3'd1,
    ST_LEN_MISMATCH = 3'd2,
    ST_BAD_VERSION  = 3'd3,
    ST_XPORT_SHORT  = 3'd4,
    ST_OVERSIZE     = 3'd5
  } status_t;

  typedef struct packed {
    status_t     status;
    logic        is_v6;
    logic [7:0]  transport_proto;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [4:0]  tcp_flag_bits;
    logic        more_fragments;
    logic [10:0] payload_offset;
  } res_t;

  function automatic logic is_ext(input logic [7:0] p);
    return (p == EXT_HOP_BY_HOP) || (p == EXT_DEST_OPTS) || (p == EXT_ROUTING) ||
           (p == EXT_FRAGMENT) || (p == EXT_AUTH) || (p == EXT_ESP) ||
           (p == EXT_MOBILITY);
  endfunction

  function automatic logic is_icmp(input logic [7:0] p);
    return (p == PR_ICMP) || (p == PR_ICMPV6);
  endfunction

  function automatic logic is_transport(input logic [7:0] p);
    return (p == PR_TCP) || (p == PR_UDP) || is_icmp(p);
  endfunction

endpackage

// ===== rtl/core/ihc_capture.sv =====
// ----------------------------------------------------------------------------
// ihc_capture
// Per-packet parse state: byte offset compare and field capture for each
// byte, plus end-of-packet status evaluation.
// ----------------------------------------------------------------------------
module ihc_capture import ihc_pkg::*; #(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
  parameter int MAX_EXT_HEADERS  = MAX_EXT_HEADERS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output res_t       res
);

  localparam int CNT_W  = $clog2(MAX_PACKET_BYTES + 1);
  // offsets can run one extension header (up to 2048 bytes) past the packet
  localparam int OFS_W  = $clog2(MAX_PACKET_BYTES + 2048);
  localparam int SEEN_W = $clog2(MAX_EXT_HEADERS + 1);
  localparam int CMP_W  = ((OFS_W > 16) ? OFS_W : 16) + 1;

  logic [CNT_W-1:0]  cnt_r,   cnt_nxt;
  logic              long_r,  long_nxt;
  logic [3:0]        ver_r,   ver_nxt;
  logic [3:0]        hw_r,    hw_nxt;
  logic [15:0]       decl_r,  decl_nxt;
  logic [7:0]        fnh_r,   fnh_nxt;
  logic [7:0]        cur_r,   cur_nxt;
  logic [OFS_W-1:0]  neo_r,   neo_nxt;
  logic              walk_r,  walk_nxt;
  logic [SEEN_W-1:0] seen_r,  seen_nxt;
  logic [OFS_W-1:0]  toff_r,  toff_nxt;
  logic [15:0]       src_r,   src_nxt;
  logic [15:0]       dst_r,   dst_nxt;
  logic [4:0]        flg_r,   flg_nxt;
  logic              frag_r,  frag_nxt;

  logic [3:0]        ver;
  logic [OFS_W-1:0]  pos;
  logic [OFS_W-1:0]  rel;
  logic [11:0]       ext_len;
  logic [SEEN_W-1:0] seen_inc;
  logic              decided;
  logic [7:0]        fin_cur;
  logic [OFS_W-1:0]  fin_toff;
  logic [4:0]        need;
  logic [CMP_W-1:0]  len_c;
  status_t           status;

  always_comb begin
    cnt_nxt  = cnt_r;
    long_nxt = long_r;
    ver_nxt  = ver_r;
    hw_nxt   = hw_r;
    decl_nxt = decl_r;
    fnh_nxt  = fnh_r;
    cur_nxt  = cur_r;
    neo_nxt  = neo_r;
    walk_nxt = walk_r;
    seen_nxt = seen_r;
    toff_nxt = toff_r;
    src_nxt  = src_r;
    dst_nxt  = dst_r;
    flg_nxt  = flg_r;
    frag_nxt = frag_r;

    ver      = (cnt_r == '0) ? data_byte[7:4] : ver_r;
    pos      = OFS_W'(cnt_r);
    ext_len  = {({1'b0, data_byte} + 9'd1), 3'b000};
    seen_inc = seen_r + 1'b1;
    decided  = 1'b0;
    rel      = '0;

    if (cnt_r >= CNT_W'(MAX_PACKET_BYTES)) begin
      long_nxt = 1'b1;
    end else begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == '0) begin
        ver_nxt = data_byte[7:4];
        hw_nxt  = data_byte[3:0];
        if (data_byte[7:4] == IP_V4) begin
          toff_nxt = OFS_W'({data_byte[3:0], 2'b00});
        end
      end

      if (ver == IP_V4) begin
        if (cnt_r == CNT_W'(2)) begin
          decl_nxt = {data_byte, 8'h00};
        end else if (cnt_r == CNT_W'(3)) begin
          decl_nxt = decl_r | {8'h00, data_byte};
        end else if (cnt_r == CNT_W'(6)) begin
          frag_nxt = data_byte[5];
        end else if (cnt_r == CNT_W'(9)) begin
          cur_nxt = data_byte;
          fnh_nxt = data_byte;
        end
      end else if (ver == IP_V6) begin
        if (cnt_r == CNT_W'(6)) begin
          fnh_nxt  = data_byte;
          cur_nxt  = data_byte;
          toff_nxt = OFS_W'(V6_HDR_BYTES);
          if (is_ext(data_byte)) begin
            walk_nxt = 1'b1;
            neo_nxt  = OFS_W'(V6_HDR_BYTES);
            seen_nxt = '0;
          end
        end else if (walk_r) begin
          if (pos == neo_r) begin
            cur_nxt = data_byte;
          end else if (pos == neo_r + 1'b1) begin
            neo_nxt  = neo_r + OFS_W'(ext_len);
            seen_nxt = seen_inc;
            if (is_transport(cur_r)) begin
              walk_nxt = 1'b0;
              toff_nxt = neo_r + OFS_W'(ext_len);
            end else if (!is_ext(cur_r) || (seen_inc >= SEEN_W'(MAX_EXT_HEADERS))) begin
              walk_nxt = 1'b0;
              cur_nxt  = fnh_r;
              toff_nxt = OFS_W'(V6_HDR_BYTES);
            end
          end
        end
      end

      decided = ((ver == IP_V4) && (cnt_r > CNT_W'(9))) ||
                ((ver == IP_V6) && (cnt_r > CNT_W'(6)) && !walk_nxt);
      rel = pos - toff_nxt;
      if (decided && is_transport(cur_nxt) && (pos >= toff_nxt)) begin
        if (is_icmp(cur_nxt)) begin
          // identifier goes to both port fields
          if (rel == OFS_W'(4)) begin
            src_nxt = {data_byte, 8'h00};
            dst_nxt = {data_byte, 8'h00};
          end else if (rel == OFS_W'(5)) begin
            src_nxt = src_r | {8'h00, data_byte};
            dst_nxt = src_r | {8'h00, data_byte};
          end
        end else begin
          if (rel == OFS_W'(0)) begin
            src_nxt = {data_byte, 8'h00};
          end else if (rel == OFS_W'(1)) begin
            src_nxt = src_r | {8'h00, data_byte};
          end else if (rel == OFS_W'(2)) begin
            dst_nxt = {data_byte, 8'h00};
          end else if (rel == OFS_W'(3)) begin
            dst_nxt = dst_r | {8'h00, data_byte};
          end else if ((rel == OFS_W'(13)) && (cur_nxt == PR_TCP)) begin
            // rst, fin, psh, ack, syn (msb first)
            flg_nxt = {data_byte[2], data_byte[0], data_byte[3], data_byte[4], data_byte[1]};
          end
        end
      end
    end
  end

  // end-of-packet evaluation on the post-byte state
  always_comb begin
    len_c    = CMP_W'(cnt_nxt);
    fin_cur  = cur_nxt;
    fin_toff = toff_nxt;
    if ((ver_nxt == IP_V6) && walk_nxt) begin
      // walk never finished: fall back to the fixed next header
      fin_cur  = fnh_nxt;
      fin_toff = OFS_W'(V6_HDR_BYTES);
    end

    if (fin_cur == PR_TCP) begin
      need = 5'(TCP_HDR_MIN);
    end else if (is_transport(fin_cur)) begin
      need = 5'(L4_HDR_MIN);
    end else begin
      need = '0;
    end

    if (long_nxt) begin
      status = ST_OVERSIZE;
    end else if (ver_nxt == IP_V4) begin
      if ((len_c < CMP_W'(V4_MIN_HDR)) || (hw_nxt < 4'(V4_MIN_IHL)) ||
          (len_c < CMP_W'({hw_nxt, 2'b00}))) begin
        status = ST_HDR_SHORT;
      end else if (CMP_W'(decl_nxt) != len_c) begin
        status = ST_LEN_MISMATCH;
      end else if ((need != '0) && (len_c < CMP_W'(fin_toff) + CMP_W'(need))) begin
        status = ST_XPORT_SHORT;
      end else begin
        status = ST_OK;
      end
    end else if (ver_nxt == IP_V6) begin
      if (len_c < CMP_W'(V6_HDR_BYTES)) begin
        status = ST_HDR_SHORT;
      end else if ((need != '0) && (len_c < CMP_W'(fin_toff) + CMP_W'(need))) begin
        status = ST_XPORT_SHORT;
      end else begin
        status = ST_OK;
      end
    end else begin
      status = ST_BAD_VERSION;
    end

    res        = '0;
    res.status = status;
    if (status == ST_OK) begin
      res.is_v6           = (ver_nxt == IP_V6);
      res.transport_proto = fin_cur;
      if (is_transport(fin_cur)) begin
        res.source_port = src_nxt;
        res.dest_port   = dst_nxt;
      end
      if (fin_cur == PR_TCP) begin
        res.tcp_flag_bits = flg_nxt;
      end
      res.more_fragments = (ver_nxt == IP_V4) && frag_nxt;
      res.payload_offset = fin_toff[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      cnt_r  <= '0;
      long_r <= 1'b0;
      ver_r  <= '0;
      hw_r   <= '0;
      decl_r <= '0;
      fnh_r  <= '0;
      cur_r  <= '0;
      neo_r  <= '0;
      walk_r <= 1'b0;
      seen_r <= '0;
      toff_r <= '0;
      src_r  <= '0;
      dst_r  <= '0;
      flg_r  <= '0;
      frag_r <= 1'b0;
    end else if (step) begin
      cnt_r  <= cnt_nxt;
      long_r <= long_nxt;
      ver_r  <= ver_nxt;
      hw_r   <= hw_nxt;
      decl_r <= decl_nxt;
      fnh_r  <= fnh_nxt;
      cur_r  <= cur_nxt;
      neo_r  <= neo_nxt;
      walk_r <= walk_nxt;
      seen_r <= seen_nxt;
      toff_r <= toff_nxt;
      src_r  <= src_nxt;
      dst_r  <= dst_nxt;
      flg_r  <= flg_nxt;
      frag_r <= frag_nxt;
    end
  end

endmodule

// ===== rtl/core/ihc_out_reg.sv =====
// ----------------------------------------------------------------------------
// ihc_out_reg
// Result register: holds one classification item until downstream takes it.
// ----------------------------------------------------------------------------
module ihc_out_reg import ihc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  logic stall,
  input  res_t d,
  output logic valid,
  output res_t q
);

  logic valid_r, valid_nxt;
  res_t q_r;

  // load only happens when the slot is empty or being drained
  assign valid_nxt = load || (valid_r && stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= d;
    end
  end

  assign valid = valid_r;
  assign q     = q_r;

endmodule

// ===== rtl/core/ip_packet_header_classifier.sv =====
// The last byte passes the input register and then loads the result register.
// Throughput: one byte per cycle; the parse stage advances each cycle unless
// the byte is a packet's last and the result register is still held.
// Reset: synchronous active-low rst_n empties both registers and clears
// the packet parse state.
// ----------------------------------------------------------------------------
// ip_packet_header_classifier
// Streams an IPv4/IPv6 packet byte by byte and emits one classification item
// (version, transport protocol, ports, TCP flags, MF bit, payload offset,
// status) per packet.
// ----------------------------------------------------------------------------
module ip_packet_header_classifier import ihc_pkg::*; #(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
  parameter int MAX_EXT_HEADERS  = MAX_EXT_HEADERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte stream in
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // classification out
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_is_v6,
  output logic [7:0]  out_transport_proto,
  output logic [15:0] out_source_port,
  output logic [15:0] out_dest_port,
  output logic [4:0]  out_tcp_flag_bits,
  output logic        out_more_fragments,
  output logic [10:0] out_payload_offset
);

  // Input register: one byte waiting for the parse stage.
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  logic in_take;
  logic advance;
  logic res_load;
  res_t res;
  res_t res_q;

  // A byte moves into the parse state every cycle, except a last byte that
  // would overwrite a result still waiting downstream.
  assign advance  = s1_valid_r && !(s1_last_r && out_valid && out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;
  assign res_load = advance && s1_last_r;

  assign s1_valid_nxt = in_take || (s1_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // Per-byte capture and end-of-packet status logic.
  ihc_capture #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
    .MAX_EXT_HEADERS  (MAX_EXT_HEADERS)
  ) u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .res       (res)
  );

  // Result register, loaded at the last byte of each packet.
  ihc_out_reg u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (res_load),
    .stall (out_stall),
    .d     (res),
    .valid (out_valid),
    .q     (res_q)
  );

  assign out_status          = res_q.status;
  assign out_is_v6           = res_q.is_v6;
  assign out_transport_proto = res_q.transport_proto;
  assign out_source_port     = res_q.source_port;
  assign out_dest_port       = res_q.dest_port;
  assign out_tcp_flag_bits   = res_q.tcp_flag_bits;
  assign out_more_fragments  = res_q.more_fragments;
  assign out_payload_offset  = res_q.payload_offset;

endmodule

// ===== rtl/core/ihc_checker.sv =====
// ----------------------------------------------------------------------------
// ihc_checker
// Port-level checks for the IP header classifier, bound to the top level.
// ----------------------------------------------------------------------------
module ihc_checker import ihc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic        out_is_v6,
  input logic [7:0]  out_transport_proto,
  input logic [15:0] out_source_port,
  input logic [15:0] out_dest_port,
  input logic [4:0]  out_tcp_flag_bits,
  input logic        out_more_fragments,
  input logic [10:0] out_payload_offset
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_source_port) && $stable(out_payload_offset))
    else $error("result changed while stalled");

  // error items carry nothing but the status
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      !out_is_v6 && (out_transport_proto == 8'd0) && (out_source_port == 16'd0) &&
      (out_dest_port == 16'd0) && (out_tcp_flag_bits == 5'd0) &&
      !out_more_fragments && (out_payload_offset == 11'd0))
    else $error("error item with nonzero fields");

  // no fragment mark on IPv6
  a_v6_no_mf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_v6 |-> !out_more_fragments)
    else $error("more_fragments set on IPv6");

  // flags only for TCP
  a_flags_tcp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_tcp_flag_bits != 5'd0) |-> (out_transport_proto == PR_TCP))
    else $error("TCP flags on non-TCP item");

  // input only backs up behind a held result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no held result");

endmodule

bind ip_packet_header_classifier ihc_checker u_ihc_checker (.*);
